FILE: design/tba_pkg.sv
`timescale 1ns / 1ps
package tba_pkg;

    localparam int MAX_BINS = 64;
    localparam int SLOT_W   = $clog2(MAX_BINS);
    localparam int CNT_W    = $clog2(MAX_BINS + 1);
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 2 * DATA_W;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_BIN_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_ALIGN_TIME  = 2'd1;
    localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

    // remainder unit handshake
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } t_mod_rsp;

endpackage

FILE: design/tba_ram.sv
`timescale 1ns / 1ps
module tba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/tba_mod.sv
`timescale 1ns / 1ps
module tba_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tba_pkg::t_mod_req i_req,
    output tba_pkg::t_mod_rsp o_rsp
);
    import tba_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic              r_done, n_done;
    logic [DATA_W:0]   trial;

    // restoring remainder, one dividend bit a cycle
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_a    = r_a;
        n_b    = r_b;
        n_done = 1'b0;
        trial  = {r_rem, r_a[DATA_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_a    = i_req.dividend;
            n_b    = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_b}) begin
                n_rem = DATA_W'(trial - {1'b0, r_b});
            end else begin
                n_rem = trial[DATA_W-1:0];
            end
            n_a  = {r_a[DATA_W-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule

FILE: design/time_bin_accumulator_top.sv
`timescale 1ns / 1ps
// Ring of up to 64 time bins kept in one 64-entry RAM (start time and Q16.16
// value per entry), with a read-modify-write sequencer. One word at a time.
// An add runs two remainder passes on the bit-serial remainder unit to find
// the aligned bin start (one pass when the stamp lies below the grid offset),
// then a backward search reads the held bins one by one from the newest, a
// gap is filled by appending bins one by one, and a full refill steps the
// grid back to find the first start and then writes one bin at a time; an
// add with a zero bin limit is rejected without a remainder pass. A result
// may also wait for the result register to drain. The sequencer parks a
// finished result until the result register is free. No clearing pass after
// reset: only held entries are read.
module time_bin_accumulator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic [31:0]               i_time_stamp,
    input  logic signed [31:0]        i_amount,
    input  logic [5:0]                i_read_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic [6:0]                o_bin_count,
    output logic [31:0]               o_read_start,
    output logic signed [31:0]        o_read_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import tba_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFF   = 4'd1;  // grid offset remainder
    localparam logic [3:0] S_TGT   = 4'd2;  // bin start remainder
    localparam logic [3:0] S_HAVE  = 4'd3;  // target known
    localparam logic [3:0] S_NEWW  = 4'd4;  // newest bin data back
    localparam logic [3:0] S_CMP   = 4'd5;  // backward search
    localparam logic [3:0] S_RFCNT = 4'd6;  // refill: find first start
    localparam logic [3:0] S_RFWR  = 4'd7;  // refill: write bins
    localparam logic [3:0] S_STEP  = 4'd8;  // append bins, amount in the last
    localparam logic [3:0] S_RDOUT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam int PROD_W = DATA_W + CNT_W;

    logic [3:0]          r_state, n_state;
    logic [DATA_W-1:0]   r_ts, n_ts;
    logic [DATA_W-1:0]   r_amt, n_amt;
    logic [DATA_W-1:0]   r_w, n_w;
    logic [CNT_W-1:0]    r_limit, n_limit;
    logic [DATA_W-1:0]   r_target, n_target;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [SLOT_W-1:0]   r_age, n_age;
    logic [DATA_W-1:0]   r_first, n_first;
    logic [SLOT_W-1:0]   r_k, n_k;
    logic [DATA_W-1:0]   r_back, n_back;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [SLOT_W-1:0]   r_oldest, n_oldest;
    logic [DATA_W-1:0]   r_bw, n_bw;
    logic [DATA_W-1:0]   r_align, n_align;
    logic [CNT_W-1:0]    r_biu, n_biu;
    logic                r_acc, n_acc;
    logic [DATA_W-1:0]   r_rs, n_rs;
    logic [DATA_W-1:0]   r_rv, n_rv;
    logic                r_out_valid, n_out_valid;
    logic                r_o_acc, n_o_acc;
    logic [CNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic [DATA_W-1:0]   r_o_rs, n_o_rs;
    logic [DATA_W-1:0]   r_o_rv, n_o_rv;

    t_mod_req            mod_req;
    t_mod_rsp            mod_rsp;

    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [DATA_W-1:0]   rd_start, rd_value;

    logic [CNT_W-1:0]    cfg_limit;
    logic [DATA_W-1:0]   diff;
    logic [DATA_W:0]     sum;
    logic [DATA_W:0]     nx;
    logic [DATA_W-1:0]   nx_sat;
    logic                nx_last;
    logic                in_take;
    logic                out_free;

    assign rd_start = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_value = ram_rdata[DATA_W-1:0];
    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_ts     = r_ts;
        n_amt    = r_amt;
        n_w      = r_w;
        n_limit  = r_limit;
        n_target = r_target;
        n_prod   = r_prod;
        n_age    = r_age;
        n_first  = r_first;
        n_k      = r_k;
        n_back   = r_back;
        n_held   = r_held;
        n_oldest = r_oldest;
        n_bw     = r_bw;
        n_align  = r_align;
        n_biu    = r_biu;
        n_acc    = r_acc;
        n_rs     = r_rs;
        n_rv     = r_rv;
        n_out_valid = r_out_valid;
        n_o_acc  = r_o_acc;
        n_o_cnt  = r_o_cnt;
        n_o_rs   = r_o_rs;
        n_o_rv   = r_o_rv;

        mod_req   = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        cfg_limit = '0;
        diff      = r_target - rd_start;
        sum       = {rd_value[DATA_W-1], rd_value} + {r_amt[DATA_W-1], r_amt};
        nx        = {1'b0, r_back} + {1'b0, r_w};
        nx_sat    = nx[DATA_W] ? '1 : nx[DATA_W-1:0];
        nx_last   = nx_sat >= r_target;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // config words arrive only while idle
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BIN_WIDTH:  n_bw    = i_cfg_data;
                CFG_ALIGN_TIME: n_align = i_cfg_data;
                CFG_BINS_IN_USE: begin
                    n_biu = i_cfg_data[CNT_W-1:0];
                    cfg_limit = (n_biu > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : n_biu;
                    if (r_held > cfg_limit) begin
                        n_oldest = r_oldest + SLOT_W'(r_held - cfg_limit);
                        n_held   = cfg_limit;
                    end
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_ts    = i_time_stamp;
                    n_amt   = i_amount;
                    n_w     = (r_bw == '0) ? DATA_W'(1) : r_bw;
                    n_limit = (r_biu > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : r_biu;
                    n_acc   = 1'b0;
                    n_rs    = '0;
                    n_rv    = '0;
                    n_state = S_DONE;
                    unique case (i_opcode)
                        OP_ADD: begin
                            if (n_limit != '0) begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = r_align;
                                mod_req.divisor  = n_w;
                                n_state = S_OFF;
                            end
                        end
                        OP_CLEAR: begin
                            n_held   = '0;
                            n_oldest = '0;
                            n_acc    = 1'b1;
                        end
                        OP_READ: begin
                            if ({1'b0, i_read_index} < r_held) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_oldest + i_read_index;
                                n_state   = S_RDOUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OFF: begin
                if (mod_rsp.done) begin
                    if (r_ts < mod_rsp.rem) begin
                        n_target = '0;
                        n_state  = S_HAVE;
                    end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = r_ts - mod_rsp.rem;
                        mod_req.divisor  = r_w;
                        n_state = S_TGT;
                    end
                end
            end
            S_TGT: begin
                if (mod_rsp.done) begin
                    n_target = r_ts - mod_rsp.rem;
                    n_state  = S_HAVE;
                end
            end
            S_HAVE: begin
                n_prod = PROD_W'(r_limit) * PROD_W'(r_w);
                if (r_held == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_oldest;
                    ram_wdata = {r_target, r_amt};
                    n_held    = CNT_W'(1);
                    n_acc     = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_oldest + SLOT_W'(r_held - 1'b1);
                    n_state   = S_NEWW;
                end
            end
            S_NEWW: begin
                if (r_target > rd_start) begin
                    if (PROD_W'(diff) >= r_prod) begin
                        n_held   = '0;
                        n_oldest = '0;
                        n_first  = r_target;
                        n_k      = '0;
                        n_state  = S_RFCNT;
                    end else begin
                        n_back  = rd_start;
                        n_state = S_STEP;
                    end
                end else begin
                    // data of the newest bin is still on the read port
                    n_age   = SLOT_W'(r_held - 1'b1);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_start == r_target) begin
                    if (sum[DATA_W] == sum[DATA_W-1]) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_oldest + r_age;
                        ram_wdata = {r_target, sum[DATA_W-1:0]};
                        n_acc     = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (rd_start < r_target || r_age == '0) begin
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_oldest + r_age - 1'b1;
                    n_age     = r_age - 1'b1;
                end
            end
            S_RFCNT: begin
                if (({1'b0, r_k} + 1'b1 < r_limit) && (r_first >= r_w)) begin
                    n_first = r_first - r_w;
                    n_k     = r_k + 1'b1;
                end else begin
                    n_state = S_RFWR;
                end
            end
            S_RFWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_held[SLOT_W-1:0];
                ram_wdata = {r_first, (r_k == '0) ? r_amt : DATA_W'(0)};
                n_first   = r_first + r_w;
                n_held    = r_held + 1'b1;
                n_k       = r_k - 1'b1;
                if (r_k == '0) begin
                    n_acc   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_STEP: begin
                // at the bin limit the oldest bin is dropped as the new one is appended
                ram_we    = 1'b1;
                ram_waddr = r_oldest + r_held[SLOT_W-1:0];
                ram_wdata = {nx_sat, nx_last ? r_amt : DATA_W'(0)};
                n_back    = nx_sat;
                if (r_held >= r_limit) begin
                    n_oldest = r_oldest + 1'b1;
                end else begin
                    n_held = r_held + 1'b1;
                end
                if (nx_last) begin
                    n_acc   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RDOUT: begin
                n_acc   = 1'b1;
                n_rs    = rd_start;
                n_rv    = rd_value;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_acc     = r_acc;
                    n_o_cnt     = r_held;
                    n_o_rs      = r_rs;
                    n_o_rv      = r_rv;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_oldest    <= '0;
            r_bw        <= DATA_W'(1);
            r_align     <= '0;
            r_biu       <= CNT_W'(MAX_BINS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_oldest    <= n_oldest;
            r_bw        <= n_bw;
            r_align     <= n_align;
            r_biu       <= n_biu;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts     <= n_ts;
        r_amt    <= n_amt;
        r_w      <= n_w;
        r_limit  <= n_limit;
        r_target <= n_target;
        r_prod   <= n_prod;
        r_age    <= n_age;
        r_first  <= n_first;
        r_k      <= n_k;
        r_back   <= n_back;
        r_acc    <= n_acc;
        r_rs     <= n_rs;
        r_rv     <= n_rv;
        r_o_acc  <= n_o_acc;
        r_o_cnt  <= n_o_cnt;
        r_o_rs   <= n_o_rs;
        r_o_rv   <= n_o_rv;
    end

    tba_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    tba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_o_acc;
    assign o_bin_count  = r_o_cnt;
    assign o_read_start = r_o_rs;
    assign o_read_value = r_o_rv;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(MAX_BINS))
        else $error("held count beyond ring size");

    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted word left sequencer idle");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> (r_state == S_OFF || r_state == S_TGT))
        else $error("remainder finished outside a waiting state");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_HAVE || r_state == S_CMP
                    || r_state == S_RFWR || r_state == S_STEP))
        else $error("ring write in unexpected state");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tba_pkg::*;

    // opcode with no meaning: must leave the ring alone
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_WORDS = 104;

    typedef struct {
        logic        accepted;
        logic [6:0]  bin_count;
        logic [31:0] read_start;
        logic [31:0] read_value;
    } t_bin_result;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] ts;
        logic [31:0] amt;
        logic [5:0]  idx;
        bit          typed;
        t_bin_result res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [31:0] i_time_stamp;
    logic signed [31:0] i_amount;
    logic [5:0]  i_read_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic [6:0]  o_bin_count;
    logic [31:0] o_read_start;
    logic signed [31:0] o_read_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    time_bin_accumulator_top i_dut (.*);

    // ---- shadow copy of the bin ring ----
    logic [31:0] ring_start [MAX_BINS];
    logic [31:0] ring_value [MAX_BINS];
    int unsigned ring_oldest;
    int unsigned ring_held;
    logic [31:0] grid_width;
    logic [31:0] grid_align;
    logic [6:0]  bin_limit;

    t_bin_result pending_results[$];
    int          fail_cnt;
    int          idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both
    bit          long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] width_eff();
        return (grid_width == 0) ? 32'd1 : grid_width;
    endfunction

    function automatic int unsigned limit_eff();
        return (bin_limit > MAX_BINS) ? MAX_BINS : bin_limit;
    endfunction

    function automatic int unsigned slot_at(int unsigned age);
        return (ring_oldest + age) % MAX_BINS;
    endfunction

    function automatic void evict_oldest();
        ring_oldest = (ring_oldest + 1) % MAX_BINS;
        ring_held--;
    endfunction

    function automatic void append_bin(logic [31:0] start, logic [31:0] val);
        int unsigned s;
        if (ring_held >= limit_eff()) evict_oldest();
        s = slot_at(ring_held);
        ring_start[s] = start;
        ring_value[s] = val;
        ring_held++;
    endfunction

    function automatic logic [31:0] bin_start_of(logic [31:0] ts);
        logic [31:0] w;
        logic [31:0] off;
        w = width_eff();
        off = grid_align % w;
        if (ts < off) return 32'd0;
        return ts - ((ts - off) % w);
    endfunction

    // false when the sum leaves the signed 32-bit range
    function automatic bit sum_into(int unsigned s, logic signed [31:0] amt);
        longint sum;
        sum = longint'($signed(ring_value[s])) + longint'(amt);
        if (sum > 64'sd2147483647 || sum < -64'sd2147483648) return 1'b0;
        ring_value[s] = sum[31:0];
        return 1'b1;
    endfunction

    function automatic bit add_amount(logic [31:0] ts, logic signed [31:0] amt);
        int unsigned lim;
        logic [31:0] w;
        logic [31:0] target;
        logic [31:0] newest;
        logic [31:0] first;
        logic [31:0] back;
        logic [32:0] nx;
        int unsigned n;
        int unsigned s;
        lim = limit_eff();
        w = width_eff();
        if (lim == 0) return 1'b0;
        target = bin_start_of(ts);
        if (ring_held == 0) begin
            append_bin(target, amt);
            return 1'b1;
        end
        newest = ring_start[slot_at(ring_held - 1)];
        if (target > newest) begin
            if ((target - newest) / w >= lim) begin
                // gap too wide: restart with contiguous empty bins up to target
                first = target;
                n = 1;
                ring_held = 0;
                ring_oldest = 0;
                while (n < lim && first >= w) begin
                    first -= w;
                    n++;
                end
                for (int unsigned i = 0; i < n; i++)
                    append_bin(first + w * i, 32'd0);
            end else begin
                back = newest;
                while (back < target) begin
                    nx = {1'b0, back} + {1'b0, w};
                    back = nx[32] ? 32'hFFFF_FFFF : nx[31:0];
                    append_bin(back, 32'd0);
                end
            end
            return sum_into(slot_at(ring_held - 1), amt);
        end
        for (int unsigned age = ring_held; age > 0; age--) begin
            s = slot_at(age - 1);
            if (ring_start[s] == target) return sum_into(s, amt);
            if (ring_start[s] < target) break;
        end
        return 1'b0;
    endfunction

    function automatic t_bin_result apply_word(logic [1:0] op, logic [31:0] ts,
                                               logic [31:0] amt, logic [5:0] idx);
        t_bin_result r;
        r = '{1'b0, 7'd0, 32'd0, 32'd0};
        case (op)
            OP_ADD: r.accepted = add_amount(ts, amt);
            OP_CLEAR: begin
                ring_held = 0;
                ring_oldest = 0;
                r.accepted = 1'b1;
            end
            OP_READ: begin
                if (idx < ring_held) begin
                    r.accepted = 1'b1;
                    r.read_start = ring_start[slot_at(idx)];
                    r.read_value = ring_value[slot_at(idx)];
                end
            end
            default: ;
        endcase
        r.bin_count = ring_held[6:0];
        return r;
    endfunction

    // ---- receiver side: random stall plus one long hold-off ----
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && hold_left == 0) begin
                hold_left = 400;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (idle_mode == 2) begin
                i_out_stall <= ($urandom_range(99) < 61);
            end else if (idle_mode == 3) begin
                i_out_stall <= ($urandom_range(99) < 36);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---- result check ----
    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.accepted) begin
                    $error("accepted: exp %0d got %0d", want.accepted, o_accepted);
                    fail_cnt++;
                end
                if (o_bin_count !== want.bin_count) begin
                    $error("bin_count: exp %0d got %0d", want.bin_count, o_bin_count);
                    fail_cnt++;
                end
                if (o_read_start !== want.read_start) begin
                    $error("read_start: exp %h got %h", want.read_start, o_read_start);
                    fail_cnt++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: exp %h got %h", want.read_value, o_read_value);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BIN_WIDTH: grid_width = data;
            CFG_ALIGN_TIME: grid_align = data;
            CFG_BINS_IN_USE: begin
                bin_limit = data[6:0];
                while (ring_held > limit_eff()) evict_oldest();
            end
            default: ;
        endcase
    endtask

    task automatic setup_grid(logic [31:0] w, logic [31:0] a, logic [6:0] lim);
        write_reg(CFG_BIN_WIDTH, w);
        write_reg(CFG_ALIGN_TIME, a);
        write_reg(CFG_BINS_IN_USE, {25'd0, lim});
    endtask

    // Sends one word; typed rows override the shadow's answer.
    task automatic send_word(t_row row);
        int gap;
        t_bin_result r;
        gap = 0;
        if ((idle_mode == 1 && $urandom_range(99) < 61) ||
            (idle_mode == 3 && $urandom_range(99) < 36))
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= row.op;
        i_time_stamp <= row.ts;
        i_amount     <= row.amt;
        i_read_index <= row.idx;
        do @(posedge i_clk); while (o_in_stall);
        r = apply_word(row.op, row.ts, row.amt, row.idx);
        pending_results.insert(pending_results.size(), row.typed ? row.res : r);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom();
            default: return 32'($signed($urandom_range(4000)) - 2000) <<< 16;
        endcase
    endfunction

    // Mostly well-formed time runs that walk the grid, plus jumps, noise, reads, clears and undefined opcodes.
    task automatic random_phase(int words, ref logic [31:0] now);
        t_row row;
        logic [31:0] w;
        int pick;
        w = width_eff();
        for (int k = 0; k < words; k++) begin
            row = '{OP_ADD, 32'd0, 32'd0, 6'd0, 1'b0, '{1'b0, 7'd0, 32'd0, 32'd0}};
            pick = $urandom_range(99);
            row.amt = rand_amount();
            row.idx = $urandom_range(63);
            if (pick < 55) begin
                now += (w < 32'h0100_0000) ? w * $urandom_range(0, 3) : $urandom_range(3);
                row.ts = now;
            end else if (pick < 65) begin
                row.ts = now - ((w < 32'h0100_0000) ? w * $urandom_range(0, 8)
                                                    : $urandom_range(0, 8));
            end else if (pick < 70) begin
                now += (w < 32'h0100_0000) ? w * $urandom_range(4, 80) : $urandom();
                row.ts = now;
            end else if (pick < 73) begin
                row.ts = $urandom();
                now = row.ts;
            end else if (pick < 92) begin
                row.op = OP_READ;
                row.idx = (ring_held > 0 && $urandom_range(3) != 0) ?
                          $urandom_range(ring_held - 1) : $urandom_range(63);
                row.ts = $urandom();
            end else if (pick < 96) begin
                row.op = OP_CLEAR;
                row.ts = $urandom();
            end else begin
                row.op = OP_NONE;
                row.ts = $urandom();
            end
            send_word(row);
        end
        end_burst();
    endtask

    initial begin
        t_row dir_rows[$];
        logic [31:0] now;
        logic [31:0] w;
        logic [31:0] a;
        logic [6:0]  lim;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_ADD;
        i_time_stamp = '0;
        i_amount = '0;
        i_read_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BIN_WIDTH;
        i_cfg_data = '0;
        fail_cnt = 0;
        idle_mode = 0;
        long_hold_req = 1'b0;
        ring_oldest = 0;
        ring_held = 0;
        grid_width = 32'd1;
        grid_align = 32'd0;
        bin_limit = 7'd64;
        for (int i = 0; i < MAX_BINS; i++) begin
            ring_start[i] = '0;
            ring_value[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset grid: width 1, offset 0, 64 bins
        dir_rows = '{
            '{OP_READ,  32'd0,         32'd0,         6'd0,  1, '{0, 0,  0, 0}},
            '{OP_ADD,   32'd100,       32'd5,         6'd0,  1, '{1, 1,  0, 0}},
            '{OP_READ,  32'd0,         32'd0,         6'd0,  1, '{1, 1,  100, 5}},
            // sum past the positive limit
            '{OP_ADD,   32'd100,       32'h7FFF_FFFF, 6'd0,  1, '{0, 1,  0, 0}},
            // older than anything held
            '{OP_ADD,   32'd99,        32'd1,         6'd0,  1, '{0, 1,  0, 0}},
            '{OP_ADD,   32'd103,       32'h8000_0000, 6'd0,  1, '{1, 4,  0, 0}},
            '{OP_READ,  32'd0,         32'd0,         6'd3,  1, '{1, 4,  103, 32'h8000_0000}},
            // sum past the negative limit
            '{OP_ADD,   32'd103,       32'hFFFF_FFFF, 6'd0,  1, '{0, 4,  0, 0}},
            // huge gap: ring refilled up to the top of time
            '{OP_ADD,   32'hFFFF_FFFF, 32'd1,         6'd0,  1, '{1, 64, 0, 0}},
            '{OP_READ,  32'd0,         32'd0,         6'd63, 1, '{1, 64, 32'hFFFF_FFFF, 1}},
            '{OP_READ,  32'd0,         32'd0,         6'd0,  1, '{1, 64, 32'hFFFF_FFC0, 0}},
            '{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, '{0, 64, 0, 0}},
            '{OP_ADD,   32'd0,         32'h7FFF_FFFF, 6'd0,  1, '{0, 64, 0, 0}},
            '{OP_CLEAR, 32'd0,         32'd0,         6'd0,  1, '{1, 0,  0, 0}},
            '{OP_ADD,   32'd0,         32'h7FFF_FFFF, 6'd0,  1, '{1, 1,  0, 0}},
            '{OP_READ,  32'd0,         32'd0,         6'd63, 1, '{0, 1,  0, 0}}
        };
        foreach (dir_rows[i]) send_word(dir_rows[i]);
        end_burst();

        // coarse grid with an offset, five bins; stamps below the offset land at 0
        setup_grid(32'd10, 32'd1234567, 7'd5);
        dir_rows = '{
            '{OP_CLEAR, 32'd0,   32'd0,         6'd0, 0, '{0, 0, 0, 0}},
            '{OP_ADD,   32'd3,   32'h0001_0000, 6'd0, 0, '{0, 0, 0, 0}},
            '{OP_ADD,   32'd17,  32'h0002_0000, 6'd0, 0, '{0, 0, 0, 0}},
            '{OP_ADD,   32'd39,  32'hFFFF_0000, 6'd0, 0, '{0, 0, 0, 0}},
            '{OP_ADD,   32'd500, 32'h0000_8000, 6'd0, 0, '{0, 0, 0, 0}},
            '{OP_READ,  32'd0,   32'd0,         6'd4, 0, '{0, 0, 0, 0}},
            '{OP_ADD,   32'd481, 32'd9,         6'd0, 0, '{0, 0, 0, 0}},
            '{OP_READ,  32'd0,   32'd0,         6'd2, 0, '{0, 0, 0, 0}}
        };
        foreach (dir_rows[i]) send_word(dir_rows[i]);
        end_burst();
        // shrinking the limit drops oldest bins; zero limit empties the ring
        // and rejects every add
        write_reg(CFG_BINS_IN_USE, 32'd2);
        write_reg(CFG_BINS_IN_USE, 32'd0);
        send_word('{OP_ADD, 32'd507, 32'd1, 6'd0, 1, '{0, 0, 0, 0}});
        end_burst();

        // random phases over changing grids and idle patterns
        now = 32'd1000;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin w = 32'd1; a = 32'd0; lim = 7'd64; end
                1: begin w = 32'hFFFF_FFFF; a = 32'hFFFF_FFFF; lim = 7'd127; end
                2: begin w = 32'd0; a = $urandom(); lim = 7'd1; end
                3: begin w = 32'd3; a = 32'hAAAA_5555; lim = 7'd0; end
                default: begin
                    w = ($urandom_range(4) == 0) ? $urandom() : $urandom_range(1, 16);
                    a = $urandom();
                    lim = ($urandom_range(3) == 0) ? $urandom_range(127)
                                                   : $urandom_range(1, 8);
                end
            endcase
            setup_grid(w, a, lim);
            idle_mode = p % 4;
            // a long receiver hold-off while the sender keeps pushing
            if (p == 4) long_hold_req = 1'b1;
            random_phase(PHASE_WORDS, now);
            // sender waits for every outstanding result
            if (p == 6) wait_drained();
        end

        idle_mode = 0;
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("results still expected: %0d", pending_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
